// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/core/bppa_pkg.sv =====
// Shared types, codes and helpers of the page pool allocator
package bppa_pkg;

  localparam int DEF_EXTENT_COUNT = 16;
  localparam int DEF_LANES        = 8;
  localparam int DEF_CPU_COUNT    = 8;

  localparam int WORD_W = 64;
  localparam int OFF_W  = 14;
  localparam int LIDX_W = OFF_W - 6;  // lane index carried by a page offset

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOPAGE  = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_DBLFREE = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;

  typedef struct packed {
    logic [1:0]       operation;
    logic [2:0]       cpu_id;
    logic             eligible;
    logic [OFF_W-1:0] page_offset;
    logic [4:0]       target_extents;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] page;
    logic [4:0]  backed_count;
  } rsp_t;

  typedef struct packed {
    logic rd;   // read the addressed word
    logic wr;   // write the addressed word
    logic clr;  // mark all lanes of one extent as fully free
  } mem_ctl_t;

  // x mod m for a 3-bit x and m >= 1
  function automatic logic [2:0] mod_small(input logic [2:0] x, input int m);
    logic [2:0] r;
    r = x;
    for (int k = 0; k < 8; k++) begin
      if (32'(r) >= m) r = 3'(32'(r) - m);
    end
    return r;
  endfunction

  // Index of the lowest set bit of a word
  function automatic logic [5:0] low_bit(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] iso;
    logic [5:0]        idx;
    iso = w & (~w + 64'd1);
    idx = '0;
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (((j >> k) & 1) == 1) idx[k] = idx[k] | iso[j];
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/bitmap_page_pool_allocator_unit.sv =====
// Bitmap page pool allocator, top level
// A command is taken when start is high and busy is low; its one result shows on
// result for exactly one cycle with done high and must be captured then, since the
// receiver cannot stall. Timing is set by the lane bitmap RAM, each word being read
// and then evaluated: a free, and an allocate that hits its hinted lane, each read
// and evaluate one lane word before busy falls. On a hint miss the scan visits the
// extents in turn and reads the lanes of each backed one. A resize sweeps the
// extents down, reading the lanes of each backed extent to check it is fully free
// and writing every lane of each retired extent, then sweeps them up again. Rejected
// or out-of-range commands never raise busy and give their result in the next cycle.
// The user must write alloc_enable through cfg_we/cfg_data only while idle; the
// block itself does not enforce it.
module bitmap_page_pool_allocator_unit #(
  parameter int EXTENT_COUNT = bppa_pkg::DEF_EXTENT_COUNT,
  parameter int LANES_PER_EXTENT = bppa_pkg::DEF_LANES,
  parameter int CPU_COUNT = bppa_pkg::DEF_CPU_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           start,
  input  bppa_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output bppa_pkg::rsp_t result
);
  import bppa_pkg::*;

  localparam int LANE_TOTAL = EXTENT_COUNT * LANES_PER_EXTENT;
  localparam int AW = $clog2(LANE_TOTAL > 1 ? LANE_TOTAL : 2);
  localparam int EW = $clog2(EXTENT_COUNT > 1 ? EXTENT_COUNT : 2);

  logic              alloc_enable;
  mem_ctl_t          ctl;
  logic [AW-1:0]     addr;
  logic [EW-1:0]     clr_ext;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_enable <= 1'b0;
    end else if (cfg_we) begin
      alloc_enable <= cfg_data;
    end
  end

  bppa_seq #(
    .EXTENT_COUNT(EXTENT_COUNT),
    .LANES_PER_EXTENT(LANES_PER_EXTENT),
    .CPU_COUNT(CPU_COUNT)
  ) u_seq (
    .clk(clk), .rst(rst), .alloc_enable(alloc_enable), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result), .ctl(ctl), .addr(addr),
    .clr_ext(clr_ext), .wdata(wdata), .rdata(rdata)
  );

  bppa_store #(
    .EXTENT_COUNT(EXTENT_COUNT),
    .LANES_PER_EXTENT(LANES_PER_EXTENT)
  ) u_store (
    .clk(clk), .rst(rst), .ctl(ctl), .addr(addr), .clr_ext(clr_ext),
    .wdata(wdata), .rdata(rdata)
  );
endmodule

// ===== rtl/core/bppa_ram.sv =====
// Generic single-port RAM with registered read
module bppa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/bppa_store.sv =====
// Lane bitmap store: RAM plus per-lane written flags (unwritten lanes read all free)
module bppa_store #(
  parameter int EXTENT_COUNT = bppa_pkg::DEF_EXTENT_COUNT,
  parameter int LANES_PER_EXTENT = bppa_pkg::DEF_LANES,
  localparam int LANE_TOTAL = EXTENT_COUNT * LANES_PER_EXTENT,
  localparam int AW = $clog2(LANE_TOTAL > 1 ? LANE_TOTAL : 2),
  localparam int EW = $clog2(EXTENT_COUNT > 1 ? EXTENT_COUNT : 2)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bppa_pkg::mem_ctl_t             ctl,
  input  logic [AW-1:0]                  addr,
  input  logic [EW-1:0]                  clr_ext,
  input  logic [bppa_pkg::WORD_W-1:0]    wdata,
  output logic [bppa_pkg::WORD_W-1:0]    rdata
);
  import bppa_pkg::*;

  logic [LANE_TOTAL-1:0] written;
  logic                  rd_written;
  logic [WORD_W-1:0]     ram_q;

  bppa_ram #(.WIDTH(WORD_W), .DEPTH(LANE_TOTAL)) u_ram (
    .clk  (clk),
    .we   (ctl.wr),
    .re   (ctl.rd),
    .addr (addr),
    .wdata(wdata),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ctl.wr) begin
      written[addr] <= 1'b1;
    end else if (ctl.clr) begin
      for (int l = 0; l < LANES_PER_EXTENT; l++) begin
        written[AW'(32'(clr_ext) * LANES_PER_EXTENT + l)] <= 1'b0;
      end
    end
    if (ctl.rd) rd_written <= written[addr];
  end

  assign rdata = rd_written ? ram_q : '1;
endmodule

// ===== rtl/core/bppa_seq.sv =====
// Operation sequencer: hinted alloc, extent scan, free, resize sweeps
module bppa_seq #(
  parameter int EXTENT_COUNT = bppa_pkg::DEF_EXTENT_COUNT,
  parameter int LANES_PER_EXTENT = bppa_pkg::DEF_LANES,
  parameter int CPU_COUNT = bppa_pkg::DEF_CPU_COUNT,
  localparam int LANE_TOTAL = EXTENT_COUNT * LANES_PER_EXTENT,
  localparam int AW = $clog2(LANE_TOTAL > 1 ? LANE_TOTAL : 2),
  localparam int EW = $clog2(EXTENT_COUNT > 1 ? EXTENT_COUNT : 2)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        alloc_enable,
  input  logic                        start,
  input  bppa_pkg::cmd_t              cmd,
  output logic                        busy,
  output logic                        done,
  output bppa_pkg::rsp_t              result,
  output bppa_pkg::mem_ctl_t          ctl,
  output logic [AW-1:0]               addr,
  output logic [EW-1:0]               clr_ext,
  output logic [bppa_pkg::WORD_W-1:0] wdata,
  input  logic [bppa_pkg::WORD_W-1:0] rdata
);
  import bppa_pkg::*;

  localparam int LW  = $clog2(LANES_PER_EXTENT > 1 ? LANES_PER_EXTENT : 2);
  localparam int CPW = $clog2(CPU_COUNT > 1 ? CPU_COUNT : 2);
  localparam int NW  = $clog2(EXTENT_COUNT + 1);
  localparam int CMPW = 10;
  localparam int POOL_PAGES = LANE_TOTAL * 64;
  // lane index / LANES_PER_EXTENT by reciprocal multiplication, exact for 8-bit indexes
  localparam int RSH  = 16;
  localparam int RMUL = ((1 << RSH) + LANES_PER_EXTENT - 1) / LANES_PER_EXTENT;
  localparam int PW   = LIDX_W + RSH + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_DN   = 3'd6;
  localparam logic [2:0] S_UP   = 3'd7;

  logic [2:0]        state;
  logic [1:0]        op;
  logic [CPW-1:0]    hidx;
  logic [LW-1:0]     own;
  logic              scan;
  logic [EW-1:0]     ext;
  logic [LW-1:0]     lane;
  logic [LW-1:0]     s;
  logic [NW-1:0]     n;
  logic [4:0]        target;
  logic [NW-1:0]     count;
  logic [EXTENT_COUNT-1:0] backed;
  logic [EW-1:0]     hint_ext  [CPU_COUNT];
  logic [LW-1:0]     hint_lane [CPU_COUNT];
  logic [5:0]        bsel;
  logic              done_next;
  rsp_t              idle_rsp;

  // offset split and word evaluation
  logic [LIDX_W-1:0] widx;
  logic [PW-1:0]     wprod;
  logic [LIDX_W-1:0] wq;
  logic [LIDX_W-1:0] wr;
  logic [5:0]        lb;
  logic [WORD_W-1:0] onehot_b;
  logic [WORD_W-1:0] freed;
  logic [2:0]        cpu_m;
  logic              last_lane;
  logic [EW-1:0]     ext_inc;

  assign widx  = cmd.page_offset[OFF_W-1:6];
  assign wprod = PW'(widx) * PW'(RMUL);
  assign wq    = LIDX_W'(wprod >> RSH);
  assign wr    = LIDX_W'(32'(widx) - 32'(wq) * LANES_PER_EXTENT);
  assign lb       = low_bit(rdata);
  assign onehot_b = WORD_W'(1) << bsel;
  assign freed    = rdata | onehot_b;
  assign cpu_m    = mod_small(cmd.cpu_id, CPU_COUNT);
  assign last_lane = lane == LW'(LANES_PER_EXTENT - 1);
  assign ext_inc   = (ext == EW'(EXTENT_COUNT - 1)) ? '0 : EW'(ext + 1'b1);

  assign busy    = state != S_IDLE;
  assign addr    = AW'(32'(ext) * LANES_PER_EXTENT + 32'(lane));
  assign clr_ext = ext;

  always_comb begin
    ctl    = '0;
    wdata  = '0;
    ctl.rd = state == S_RD;
    if (state == S_EVAL && op == OP_ALLOC && rdata != '0) begin
      ctl.wr = 1'b1;
      wdata  = rdata & ~(WORD_W'(1) << lb);
    end else if (state == S_EVAL && op == OP_FREE && !rdata[bsel]) begin
      ctl.wr = 1'b1;
      wdata  = freed;
    end else if (state == S_CLR) begin
      ctl.wr = 1'b1;
    end
    ctl.clr = state == S_UP && n != '0 && CMPW'(count) < CMPW'(target) && !backed[ext];
  end

  // result as loaded when a command is taken
  always_comb begin
    idle_rsp = '0;
    idle_rsp.status = ST_NOPAGE;
    if (cmd.operation == OP_FREE && 32'(cmd.page_offset) >= POOL_PAGES) begin
      idle_rsp.status = ST_OUTSIDE;
    end
    if (cmd.operation == OP_RESIZE) begin
      idle_rsp.backed_count = 5'(count);
    end
  end

  always_comb begin
    done_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.operation)
            OP_ALLOC:  done_next = !(alloc_enable && cmd.eligible);
            OP_FREE:   done_next = 32'(cmd.page_offset) >= POOL_PAGES;
            OP_RESIZE: done_next = 32'(cmd.target_extents) > EXTENT_COUNT;
            default:   done_next = 1'b1;
          endcase
        end
      end
      S_EVAL:  done_next = (op == OP_ALLOC && rdata != '0) || op == OP_FREE;
      S_SCAN:  done_next = n == NW'(EXTENT_COUNT);
      S_UP:    done_next = n == '0 || CMPW'(count) >= CMPW'(target);
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      backed <= '1;
      count  <= NW'(EXTENT_COUNT);
      for (int i = 0; i < CPU_COUNT; i++) begin
        hint_ext[i]  <= '0;
        hint_lane[i] <= LW'(i % LANES_PER_EXTENT);
      end
    end else begin
      done <= done_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= cmd.operation;
            hidx   <= CPW'(cpu_m);
            own    <= LW'(mod_small(cpu_m, LANES_PER_EXTENT));
            target <= cmd.target_extents;
            result <= idle_rsp;
            scan   <= 1'b0;
            case (cmd.operation)
              OP_ALLOC: begin
                if (alloc_enable && cmd.eligible) begin
                  ext   <= hint_ext[CPW'(cpu_m)];
                  lane  <= hint_lane[CPW'(cpu_m)];
                  state <= S_RD;
                end
              end
              OP_FREE: begin
                if (32'(cmd.page_offset) < POOL_PAGES) begin
                  ext   <= EW'(wq);
                  lane  <= LW'(wr);
                  bsel  <= cmd.page_offset[5:0];
                  state <= S_RD;
                end
              end
              OP_RESIZE: begin
                if (32'(cmd.target_extents) <= EXTENT_COUNT) begin
                  ext   <= EW'(EXTENT_COUNT - 1);
                  n     <= NW'(EXTENT_COUNT);
                  state <= S_DN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          case (op)
            OP_ALLOC: begin
              if (rdata != '0) begin
                result <= {ST_OK, 13'({addr, lb}), 5'd0};
                if (scan) begin
                  hint_ext[hidx]  <= ext;
                  hint_lane[hidx] <= lane;
                end
                state <= S_IDLE;
              end else if (!scan) begin
                scan  <= 1'b1;
                n     <= '0;
                state <= S_SCAN;
              end else if (s == LW'(LANES_PER_EXTENT - 1)) begin
                ext   <= ext_inc;
                n     <= NW'(n + 1'b1);
                state <= S_SCAN;
              end else begin
                s     <= LW'(s + 1'b1);
                lane  <= last_lane ? '0 : LW'(lane + 1'b1);
                state <= S_RD;
              end
            end
            OP_FREE: begin
              if (rdata[bsel]) begin
                result.status <= ST_DBLFREE;
              end else begin
                result.status <= ST_OK;
                if (lane == own && freed == '1) begin
                  hint_ext[hidx]  <= ext;
                  hint_lane[hidx] <= lane;
                end
              end
              state <= S_IDLE;
            end
            default: begin
              // resize: checking that an extent is fully free
              if (rdata != '1) begin
                ext   <= EW'(ext - 1'b1);
                n     <= NW'(n - 1'b1);
                state <= S_DN;
              end else if (last_lane) begin
                lane  <= '0;
                state <= S_CLR;
              end else begin
                lane  <= LW'(lane + 1'b1);
                state <= S_RD;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (n == NW'(EXTENT_COUNT)) begin
            result <= {ST_NOPAGE, 13'd0, 5'd0};
            state  <= S_IDLE;
          end else if (backed[ext]) begin
            lane  <= own;
            s     <= '0;
            state <= S_RD;
          end else begin
            ext <= ext_inc;
            n   <= NW'(n + 1'b1);
          end
        end
        S_CLR: begin
          if (last_lane) begin
            backed[ext] <= 1'b0;
            count <= NW'(count - 1'b1);
            ext   <= EW'(ext - 1'b1);
            n     <= NW'(n - 1'b1);
            state <= S_DN;
          end else begin
            lane <= LW'(lane + 1'b1);
          end
        end
        S_DN: begin
          if (n == '0 || CMPW'(count) <= CMPW'(target)) begin
            ext   <= '0;
            n     <= NW'(EXTENT_COUNT);
            state <= S_UP;
          end else if (!backed[ext]) begin
            ext <= EW'(ext - 1'b1);
            n   <= NW'(n - 1'b1);
          end else begin
            lane  <= '0;
            state <= S_RD;
          end
        end
        S_UP: begin
          if (n == '0 || CMPW'(count) >= CMPW'(target)) begin
            result <= {(CMPW'(count) == CMPW'(target)) ? ST_OK : ST_BUSY, 13'd0, 5'(count)};
            state  <= S_IDLE;
          end else begin
            if (!backed[ext]) begin
              backed[ext] <= 1'b1;
              count <= NW'(count + 1'b1);
            end
            ext <= ext_inc;
            n   <= NW'(n - 1'b1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/bppa_chk.sv =====
// Port-level checker for the allocator, bound to the top level
`include "assert_macros.svh"

module bppa_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input bppa_pkg::cmd_t cmd,
  input bppa_pkg::rsp_t result
);
  import bppa_pkg::*;

  logic free_in_pool;

  assign free_in_pool = cmd.operation == OP_FREE && cmd.page_offset[13] == 1'b0;

  `CHK_NEXT(a_busy_after_start, start && !busy && free_in_pool, busy)
  `CHK_SAME(a_done_idle, done, !busy)
  `CHK_SAME(a_status_range, done, result.status <= ST_OUTSIDE)
  `CHK_SAME(a_page_zero, done && result.status != ST_OK, result.page == '0)
  `CHK_NEXT(a_no_stray_done, !busy && !start, !done)
endmodule

bind bitmap_page_pool_allocator_unit bppa_chk u_chk (.*);
